[sv/scpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, types and codes of the size class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int WORD_BYTES        = 8;
  localparam int CLASS_COUNT       = 16;
  localparam int ARENA_BYTES       = 4096;
  localparam int LARGE_BLOCK_BYTES = 512;

  localparam int OFS_W       = 16;
  localparam int WORD_SHIFT  = $clog2(WORD_BYTES);
  localparam int ARENA_SHIFT = $clog2(ARENA_BYTES);
  localparam int CLS_W       = $clog2(CLASS_COUNT);
  localparam int LINK_AW     = OFS_W - WORD_SHIFT;
  localparam int LINK_W      = OFS_W + 1;
  localparam int REQ_WORDS_W = OFS_W - WORD_SHIFT + 1;
  localparam int LARGE_WORDS = LARGE_BLOCK_BYTES / WORD_BYTES;
  localparam int SIZE_W      = $clog2(LARGE_BLOCK_BYTES + 1);
  localparam int CNT_W       = $clog2(ARENA_BYTES / WORD_BYTES + 1);
  localparam int ACC_W       = SIZE_W + CNT_W + 1;
  localparam int COPY_W      = 10;
  localparam int ACT_W       = 2;

  localparam logic [CLS_W-1:0] TOP_CLASS = CLS_W'(CLASS_COUNT - 1);

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_POP,
    ST_CHK,
    ST_OFS,
    ST_PUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [OFS_W-1:0] request_size;
    logic [OFS_W-1:0] block_offset;
    logic             no_block;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0]  result_offset;
    logic              failed;
    logic              moved;
    logic [COPY_W-1:0] copy_length;
  } rsp_t;

  // one multiply-add issue to the shared unit
  typedef struct packed {
    logic              en;
    logic [SIZE_W-1:0] a;
    logic [CNT_W-1:0]  b;
    logic [OFS_W-1:0]  c;
  } alu_req_t;

endpackage
`default_nettype wire

[sv/scpa_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scpa_alu
// Shared multiply-add unit: acc = a * b + c, registered.
// ----------------------------------------------------------------------------
module scpa_alu
  import scpa_pkg::*;
(
  input  wire logic             clk,
  input  wire alu_req_t         op,
  output logic      [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = ACC_W'(op.a * op.b) + ACC_W'(op.c);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

[sv/scpa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scpa_ctrl
// Request sequencer with free list heads, bump counts and the link memory.
// ----------------------------------------------------------------------------
module scpa_ctrl
  import scpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire req_t             in_req,
  output logic                  idle,
  output logic                  done,
  output rsp_t                  rsp,
  input  wire logic             rsp_take,
  output alu_req_t              alu_op,
  input  wire logic [ACC_W-1:0] alu_acc
);

  state_t state_r, state_nxt;
  req_t   req_r;

  logic [OFS_W-1:0]  res_ofs_r, res_ofs_nxt;
  logic              fail_r, fail_nxt;
  logic              mov_r, mov_nxt;
  logic [COPY_W-1:0] copy_r, copy_nxt;

  logic              head_v_r   [CLASS_COUNT];
  logic [OFS_W-1:0]  head_ofs_r [CLASS_COUNT];
  logic [CNT_W-1:0]  count_r    [CLASS_COUNT];
  logic [LINK_W-1:0] link_mem   [2**LINK_AW];
  logic [LINK_W-1:0] link_rdata_r;

  logic [OFS_W:0]       req_sum;
  logic [REQ_WORDS_W-1:0] req_words;
  logic                 bad_size;
  logic                 new_top;
  logic [CLS_W-1:0]     new_cls;
  logic [SIZE_W-1:0]    new_blk_bytes;
  logic [OFS_W-1:0]     old_cls_full;
  logic [CLS_W-1:0]     old_cls;
  logic                 old_in_pool;
  logic [SIZE_W-1:0]    old_blk_bytes;
  logic [SIZE_W-1:0]    min_size;
  logic                 is_alloc;
  logic                 resize_move;
  logic [LINK_AW-1:0]   link_raddr;
  logic                 pop_we, bump_we, push_we;

  // size decode
  always_comb begin
    req_sum       = (OFS_W+1)'(req_r.request_size) + (OFS_W+1)'(WORD_BYTES - 1);
    req_words     = REQ_WORDS_W'(req_sum >> WORD_SHIFT);
    bad_size      = (req_words == '0) || (req_words > REQ_WORDS_W'(LARGE_WORDS));
    new_top       = req_words >= REQ_WORDS_W'(CLASS_COUNT);
    new_cls       = new_top ? TOP_CLASS : CLS_W'(req_words - REQ_WORDS_W'(1));
    new_blk_bytes = new_top ? SIZE_W'(LARGE_BLOCK_BYTES)
                            : SIZE_W'({new_cls + CLS_W'(1), WORD_SHIFT'(0)});
    old_cls_full  = req_r.block_offset >> ARENA_SHIFT;
    old_cls       = old_cls_full[CLS_W-1:0];
    old_in_pool   = old_cls_full < OFS_W'(CLASS_COUNT);
    old_blk_bytes = (old_cls_full >= OFS_W'(CLASS_COUNT - 1))
                    ? SIZE_W'(LARGE_BLOCK_BYTES)
                    : SIZE_W'({old_cls + CLS_W'(1), WORD_SHIFT'(0)});
    min_size      = (old_blk_bytes < new_blk_bytes) ? old_blk_bytes : new_blk_bytes;
    is_alloc      = (req_r.action == ACT_ALLOC) ||
                    ((req_r.action == ACT_RESIZE) && req_r.no_block);
    resize_move   = (req_r.action == ACT_RESIZE) && !req_r.no_block;
    link_raddr    = head_ofs_r[new_cls][OFS_W-1:WORD_SHIFT];
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    res_ofs_nxt = res_ofs_r;
    fail_nxt    = fail_r;
    mov_nxt     = mov_r;
    copy_nxt    = copy_r;
    pop_we      = 1'b0;
    bump_we     = 1'b0;
    push_we     = 1'b0;
    alu_op      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_ofs_nxt = '0;
          fail_nxt    = 1'b0;
          mov_nxt     = 1'b0;
          copy_nxt    = '0;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        case (req_r.action)
          ACT_FREE: begin
            state_nxt = (!req_r.no_block && old_in_pool) ? ST_PUSH : ST_DONE;
          end
          ACT_ALLOC, ACT_RESIZE: begin
            if (bad_size) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else if (!is_alloc && (new_blk_bytes == old_blk_bytes)) begin
              res_ofs_nxt = req_r.block_offset;
              state_nxt   = ST_DONE;
            end else if (head_v_r[new_cls]) begin
              res_ofs_nxt = head_ofs_r[new_cls];
              state_nxt   = ST_POP;
            end else begin
              // room check: size * (count + 1) against the arena
              alu_op.en = 1'b1;
              alu_op.a  = new_blk_bytes;
              alu_op.b  = count_r[new_cls] + CNT_W'(1);
              alu_op.c  = '0;
              state_nxt = ST_CHK;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_POP: begin
        pop_we = 1'b1;
        if (resize_move) begin
          mov_nxt   = 1'b1;
          copy_nxt  = COPY_W'(min_size);
          state_nxt = old_in_pool ? ST_PUSH : ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHK: begin
        if (alu_acc <= ACC_W'(ARENA_BYTES)) begin
          alu_op.en = 1'b1;
          alu_op.a  = new_blk_bytes;
          alu_op.b  = count_r[new_cls];
          alu_op.c  = OFS_W'({new_cls, ARENA_SHIFT'(0)});
          state_nxt = ST_OFS;
        end else begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_OFS: begin
        bump_we     = 1'b1;
        res_ofs_nxt = alu_acc[OFS_W-1:0];
        if (resize_move) begin
          mov_nxt   = 1'b1;
          copy_nxt  = COPY_W'(min_size);
          state_nxt = old_in_pool ? ST_PUSH : ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUSH: begin
        push_we   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head_v_r[i] <= 1'b0;
        count_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (pop_we) begin
        head_v_r[new_cls] <= link_rdata_r[OFS_W];
      end
      if (bump_we) begin
        count_r[new_cls] <= count_r[new_cls] + CNT_W'(1);
      end
      if (push_we) begin
        head_v_r[old_cls] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (state_r == ST_IDLE)) begin
      req_r <= in_req;
    end
    res_ofs_r <= res_ofs_nxt;
    fail_r    <= fail_nxt;
    mov_r     <= mov_nxt;
    copy_r    <= copy_nxt;
    if (pop_we) begin
      head_ofs_r[new_cls] <= link_rdata_r[OFS_W-1:0];
    end
    if (push_we) begin
      head_ofs_r[old_cls] <= req_r.block_offset;
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_we) begin
      link_mem[req_r.block_offset[OFS_W-1:WORD_SHIFT]] <=
        {head_v_r[old_cls], head_ofs_r[old_cls]};
    end
    link_rdata_r <= link_mem[link_raddr];
  end

  assign idle = (state_r == ST_IDLE);
  assign done = (state_r == ST_DONE);

  always_comb begin
    rsp.result_offset = res_ofs_r;
    rsp.failed        = fail_r;
    rsp.moved         = mov_r;
    rsp.copy_length   = copy_r;
  end

endmodule
`default_nettype wire

[sv/size_class_pool_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// Segregated free list allocator with one arena per size class.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle. A request that ends at
// decode (size out of range, resize kept in place, null free, unused code)
// goes straight to the result; a free pushes the block on its list, an
// allocate from a free list pops the head, a bump allocate checks room and
// then forms the offset, and a resize that moves the block also pushes the
// old one if it lies in the pool. The sequencer steps through the head,
// count and link memory accesses and the single shared multiply-add unit,
// issued twice for a bump allocate (room check, then offset). The result sits
// in an output register, so the next request is accepted while it waits to be
// taken. Offsets are pool relative; copying and zeroing are done outside.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_core
  import scpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // request_size[15:0], block_offset[31:16]
  input  wire logic [2:0]  in_tuser,   // action[1:0], no_block[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // result_offset[15:0], copy_length[25:16]
  output logic [1:0]       out_tuser   // failed[0], moved[1]
);

  req_t             in_req;
  rsp_t             ctrl_rsp;
  alu_req_t         alu_op;
  logic [ACC_W-1:0] alu_acc;
  logic             ctrl_idle, ctrl_done, in_fire, rsp_load;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;

  assign in_req.action       = in_tuser[ACT_W-1:0];
  assign in_req.no_block     = in_tuser[ACT_W];
  assign in_req.request_size = in_tdata[OFS_W-1:0];
  assign in_req.block_offset = in_tdata[2*OFS_W-1:OFS_W];

  assign in_tready = ctrl_idle;
  assign in_fire   = in_tvalid && ctrl_idle;
  assign rsp_load  = ctrl_done && (!out_valid_r || out_tready);

  scpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_req   (in_req),
    .idle     (ctrl_idle),
    .done     (ctrl_done),
    .rsp      (ctrl_rsp),
    .rsp_take (rsp_load),
    .alu_op   (alu_op),
    .alu_acc  (alu_acc)
  );

  scpa_alu u_alu (
    .clk (clk),
    .op  (alu_op),
    .acc (alu_acc)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_rsp_r <= ctrl_rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(32 - OFS_W - COPY_W)'(0), out_rsp_r.copy_length,
                       out_rsp_r.result_offset};
  assign out_tuser  = {out_rsp_r.moved, out_rsp_r.failed};

endmodule
`default_nettype wire

[tb/sv/tb_size_class_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_size_class_pool_allocator_core
// Self-checking bench for the segregated free list pool allocator. A queue of
// allocate, free and resize requests feeds a stream driver. A built-in model
// of the class heads, bump counts and link words predicts every response, and
// a monitor compares each one in order. Idling on both sides varies by phase,
// and one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
module tb_size_class_pool_allocator_core
  import scpa_pkg::*;
();

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;  // unused action code
  localparam int TOP_CLS     = CLASS_COUNT - 1;
  localparam int LINK_DEPTH  = 65536 / WORD_BYTES;
  localparam int HOLD_LEN    = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 540;
  localparam int LIVE_CAP    = 300;

  typedef struct {
    req_t cmd;
    rsp_t want;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // request_size[15:0], block_offset[31:16]
  logic [2:0]  in_tuser = '0;   // action[1:0], no_block[2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // result_offset[15:0], copy_length[25:16]
  logic [1:0]  out_tuser;       // failed[0], moved[1]

  logic        in_fire = 1'b0;
  int          send_idle_pct = 32;
  int          recv_idle_pct = 55;
  bit          hold_armed = 1'b0;
  int          hold_cycles = 0;
  int          mismatch_count = 0;

  pending_t    request_backlog[$];
  rsp_t        predicted_grants[$];
  int          live_blocks[$];

  // allocator state as the model sees it
  logic [16:0] list_head [CLASS_COUNT] = '{default: '0};
  int          bump_used [CLASS_COUNT] = '{default: 0};
  logic [16:0] link_word [LINK_DEPTH]  = '{default: '0};

  always #4 clk = ~clk;

  size_class_pool_allocator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic int round_to_words(int bytes);
    return ((bytes + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
  endfunction

  // size is rounded, nonzero and not above the large block
  function automatic bit take_from_class(input int size, output int ofs);
    int sz;
    int cls;
    sz  = size;
    cls = sz / WORD_BYTES - 1;
    ofs = 0;
    if (cls >= TOP_CLS) begin
      sz  = LARGE_BLOCK_BYTES;
      cls = TOP_CLS;
    end
    if (list_head[cls][16]) begin
      ofs = int'(list_head[cls][15:0]);
      list_head[cls] = link_word[ofs / WORD_BYTES];
      return 1'b1;
    end
    if (bump_used[cls] != ARENA_BYTES / sz) begin
      ofs = (cls * ARENA_BYTES + sz * bump_used[cls]) & 'hFFFF;
      bump_used[cls]++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void return_block(int ofs);
    int cls;
    cls = ofs / ARENA_BYTES;
    if (cls >= CLASS_COUNT) return;
    // link lives in the word holding the offset, head keeps the offset as is
    link_word[(ofs / WORD_BYTES) % LINK_DEPTH] = list_head[cls];
    list_head[cls] = {1'b1, ofs[15:0]};
  endfunction

  function automatic rsp_t predict_grant(req_t cmd);
    rsp_t r;
    int   new_sz;
    int   old_sz;
    int   blk;
    int   ofs;
    r      = '0;
    blk    = int'(cmd.block_offset);
    new_sz = round_to_words(int'(cmd.request_size));
    if (cmd.action == ACT_ALLOC || (cmd.action == ACT_RESIZE && cmd.no_block)) begin
      if (new_sz == 0 || new_sz > LARGE_BLOCK_BYTES) begin
        r.failed = 1'b1;
      end else if (take_from_class(new_sz, ofs)) begin
        r.result_offset = ofs[15:0];
      end else begin
        r.failed = 1'b1;
      end
    end else if (cmd.action == ACT_FREE) begin
      if (!cmd.no_block) return_block(blk);
    end else if (cmd.action == ACT_RESIZE) begin
      old_sz = (blk / ARENA_BYTES) * WORD_BYTES + WORD_BYTES;
      if (new_sz == 0 || new_sz > LARGE_BLOCK_BYTES) begin
        r.failed = 1'b1;
      end else begin
        if (new_sz > TOP_CLS * WORD_BYTES) new_sz = LARGE_BLOCK_BYTES;
        if (old_sz > TOP_CLS * WORD_BYTES) old_sz = LARGE_BLOCK_BYTES;
        if (new_sz == old_sz) begin
          r.result_offset = cmd.block_offset;
        end else if (take_from_class(new_sz, ofs)) begin
          r.result_offset = ofs[15:0];
          r.moved         = 1'b1;
          r.copy_length   = COPY_W'(old_sz < new_sz ? old_sz : new_sz);
          return_block(blk);
        end else begin
          r.failed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request generation
  // --------------------------------------------------------------------------
  function automatic void forget_block(int ofs);
    foreach (live_blocks[j]) begin
      if (live_blocks[j] == ofs) begin
        live_blocks.delete(j);
        return;
      end
    end
  endfunction

  task automatic queue_request(input logic [ACT_W-1:0] act, input int size, input int ofs,
                               input bit nb);
    pending_t p;
    p.cmd.action       = act;
    p.cmd.request_size = size[15:0];
    p.cmd.block_offset = ofs[15:0];
    p.cmd.no_block     = nb;
    p.want             = predict_grant(p.cmd);
    request_backlog.push_back(p);
    if (act == ACT_ALLOC || (act == ACT_RESIZE && nb)) begin
      if (!p.want.failed) live_blocks.push_back(int'(p.want.result_offset));
    end else if (act == ACT_FREE && !nb) begin
      forget_block(ofs & 'hFFFF);
    end else if (act == ACT_RESIZE && p.want.moved) begin
      forget_block(ofs & 'hFFFF);
      live_blocks.push_back(int'(p.want.result_offset));
    end
  endtask

  function automatic int random_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(120, 1);
    if (r < 90) return $urandom_range(512, 121);
    if (r < 95) return $urandom_range(8, 0);
    return $urandom_range(65535);
  endfunction

  task automatic queue_random_request();
    int k;
    int pick;
    k = $urandom_range(99);
    if (k < 88) begin
      if (live_blocks.size() == 0 || (k < 40 && live_blocks.size() < LIVE_CAP)) begin
        queue_request(ACT_ALLOC, random_size(), $urandom_range(65535),
                      1'($urandom_range(1)));
      end else begin
        pick = live_blocks[$urandom_range(live_blocks.size() - 1)];
        if (k < 68) queue_request(ACT_FREE, $urandom_range(65535), pick, 1'b0);
        else        queue_request(ACT_RESIZE, random_size(), pick, 1'b0);
      end
    end else begin
      // noise: stray offsets, null blocks, wild sizes, unused code
      case ($urandom_range(5))
        0: queue_request(ACT_FREE, $urandom_range(65535), $urandom_range(65535), 1'b0);
        1: queue_request(ACT_FREE, $urandom_range(65535), $urandom_range(65535), 1'b1);
        2: queue_request(ACT_RESIZE, random_size(), $urandom_range(65535), 1'b1);
        3: queue_request(ACT_ALLOC, $urandom_range(65535), $urandom_range(65535), 1'b0);
        4: queue_request(ACT_NONE, $urandom_range(65535), $urandom_range(65535),
                         1'($urandom_range(1)));
        default: queue_request(ACT_RESIZE, $urandom_range(65535), $urandom_range(65535),
                               1'b0);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // driver, receiver, monitor
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_fire) request_backlog.delete(0);
      if (in_tvalid && !in_fire) begin
        // request still waiting for tready
      end else if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {request_backlog[0].cmd.block_offset, request_backlog[0].cmd.request_size};
        in_tuser  <= {request_backlog[0].cmd.no_block, request_backlog[0].cmd.action};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_armed && hold_cycles < HOLD_LEN) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_grants
    rsp_t got;
    rsp_t want;
    bit   orphan;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_offset = out_tdata[15:0];
      got.copy_length   = out_tdata[25:16];
      got.failed        = out_tuser[0];
      got.moved         = out_tuser[1];
      orphan = (predicted_grants.size() == 0);
      want   = orphan ? rsp_t'('0) : predicted_grants.pop_front();
      if (orphan || got !== want) begin
        if (mismatch_count < 10)
          $display("mismatch%s: want ofs=%h f=%b m=%b c=%0d, got ofs=%h f=%b m=%b c=%0d",
                   orphan ? " (no request outstanding)" : "",
                   want.result_offset, want.failed, want.moved, want.copy_length,
                   got.result_offset, got.failed, got.moved, got.copy_length);
        mismatch_count++;
      end
    end
    if (rst_n && in_tvalid && in_tready) predicted_grants.push_back(request_backlog[0].want);
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int phase;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    queue_request(ACT_ALLOC, 0, 0, 1'b0);             // zero size fails
    queue_request(ACT_ALLOC, 1, 16'hFFFF, 1'b0);      // class 0 at 0x0000
    queue_request(ACT_ALLOC, 8, 0, 1'b1);             // class 0 at 0x0008
    queue_request(ACT_ALLOC, 9, 0, 1'b0);             // class 1
    queue_request(ACT_ALLOC, 120, 0, 1'b0);           // last word class
    queue_request(ACT_ALLOC, 121, 0, 1'b0);           // goes to large class, 0xF000
    queue_request(ACT_ALLOC, 512, 0, 1'b0);           // 0xF200
    queue_request(ACT_ALLOC, 513, 0, 1'b0);           // oversize
    queue_request(ACT_ALLOC, 65535, 16'hFFFF, 1'b1);  // rounds past 16 bits
    queue_request(ACT_FREE, 0, 16'h0000, 1'b0);
    queue_request(ACT_ALLOC, 5, 0, 1'b0);             // pops 0x0000
    queue_request(ACT_FREE, 65535, 16'hFFFF, 1'b1);   // null free
    queue_request(ACT_FREE, 0, 16'h1003, 1'b0);       // unaligned free
    queue_request(ACT_ALLOC, 16, 0, 1'b0);            // pops 0x1003
    queue_request(ACT_RESIZE, 24, 16'h7777, 1'b1);    // null resize allocates 0x2000
    queue_request(ACT_RESIZE, 17, 16'h2000, 1'b0);    // same class, kept
    queue_request(ACT_RESIZE, 40, 16'h2000, 1'b0);    // grows, moves
    queue_request(ACT_RESIZE, 8, 16'hF000, 1'b0);     // shrinks from large class
    queue_request(ACT_RESIZE, 0, 16'h4000, 1'b0);     // zero size resize fails
    queue_request(ACT_RESIZE, 600, 16'h4000, 1'b0);   // oversize resize fails
    queue_request(ACT_NONE, 65535, 16'hFFFF, 1'b1);
    for (i = 0; i < 7; i++) queue_request(ACT_ALLOC, 512, 0, 1'b0);  // fill large arena
    queue_request(ACT_RESIZE, 300, 16'h0010, 1'b0);   // no room, old block kept

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 55;
        recv_idle_pct = 32;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) queue_random_request();
      while (request_backlog.size() != 0) @(posedge clk);
    end

    while (predicted_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
